// ===== design/arn_pkg.sv =====
package arn_pkg;

  // block dimensions
  localparam int CHANNELS      = 5;
  localparam int SAMPLE_BITS   = 12;
  localparam int FRACTION_BITS = 16;
  localparam int NORM_BITS     = FRACTION_BITS + 1;
  localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STEP_W        = $clog2(FRACTION_BITS + 1);

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_AUTO_CALIBRATE = PADDR_W'(0);

  localparam logic [NORM_BITS-1:0] NORM_ONE = NORM_BITS'(1) << FRACTION_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [NORM_BITS-1:0]   norm_t;

  // input word commands
  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_LOAD_LOW  = 2'd1,
    CMD_LOAD_HIGH = 2'd2,
    CMD_RESERVED  = 2'd3
  } arn_cmd_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_HOLD = 3'b100
  } arn_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic            accept;
    logic            init;
    logic            iterate;
    logic            finish;
    logic            publish;
    logic [CH_W-1:0] ch;
  } arn_ctrl_t;

endpackage

// ===== design/arn_ctrl.sv =====
module arn_ctrl import arn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] command_i,
  input  logic       out_stall_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output arn_ctrl_t  ctrl_o
);

  arn_state_e        state_q, state_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              last_step;
  logic              publish;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign last_step = (step_q == STEP_W'(FRACTION_BITS));
  assign publish   = (state_q == ST_HOLD) && (!out_valid_q || !out_stall_i);

  // sequencing over channels and divider steps
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept && (arn_cmd_e'(command_i) == CMD_SAMPLE)) begin
          state_d = ST_CALC;
          ch_d    = '0;
          step_d  = '0;
        end
      end
      ST_CALC: begin
        if (last_step) begin
          step_d = '0;
          if (ch_q == CH_W'(CHANNELS - 1)) begin
            state_d = ST_HOLD;
          end else begin
            ch_d = ch_q + 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_HOLD: begin
        if (publish) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // command outputs
  assign ctrl_o.accept  = accept;
  assign ctrl_o.init    = (state_q == ST_CALC) && (step_q == '0);
  assign ctrl_o.iterate = (state_q == ST_CALC) && (step_q != '0);
  assign ctrl_o.finish  = (state_q == ST_CALC) && last_step;
  assign ctrl_o.publish = publish;
  assign ctrl_o.ch      = ch_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== design/arn_datapath.sv =====
module arn_datapath import arn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arn_ctrl_t  ctrl_i,
  input  logic       auto_cal_i,
  input  logic [1:0] command_i,
  input  sample_t    values_i [CHANNELS],
  output norm_t      norm_o [CHANNELS]
);

  sample_t lo_q [CHANNELS];
  sample_t hi_q [CHANNELS];
  logic    calib_q;
  sample_t samp_q [CHANNELS];

  sample_t                  rem_q, range_q;
  logic [FRACTION_BITS-1:0] quo_q;
  logic                     zero_q, one_q;
  norm_t                    res_q [CHANNELS];
  norm_t                    norm_q [CHANNELS];

  sample_t                  s_sel, lo_sel, hi_sel;
  logic [SAMPLE_BITS:0]     shifted;
  logic                     fits;
  sample_t                  rem_next;
  logic [FRACTION_BITS-1:0] quo_next;
  norm_t                    result;

  // bound updates and loads at word acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '0;
      end
      calib_q <= 1'b0;
    end else if (ctrl_i.accept) begin
      case (arn_cmd_e'(command_i))
        CMD_LOAD_LOW: begin
          for (int i = 0; i < CHANNELS; i++) lo_q[i] <= values_i[i];
          calib_q <= 1'b1;
        end
        CMD_LOAD_HIGH: begin
          for (int i = 0; i < CHANNELS; i++) hi_q[i] <= values_i[i];
          calib_q <= 1'b1;
        end
        CMD_SAMPLE: begin
          if (auto_cal_i) begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (!calib_q) begin
                lo_q[i] <= values_i[i];
                hi_q[i] <= values_i[i];
              end else if (values_i[i] < lo_q[i]) begin
                lo_q[i] <= values_i[i];
              end else if (values_i[i] > hi_q[i]) begin
                hi_q[i] <= values_i[i];
              end
            end
            calib_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sample capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      for (int i = 0; i < CHANNELS; i++) samp_q[i] <= values_i[i];
    end
  end

  // current channel operands
  assign s_sel  = samp_q[ctrl_i.ch];
  assign lo_sel = lo_q[ctrl_i.ch];
  assign hi_sel = hi_q[ctrl_i.ch];

  // one restoring division step
  assign shifted  = {rem_q, 1'b0};
  assign fits     = (shifted >= {1'b0, range_q});
  assign rem_next = fits ? SAMPLE_BITS'(shifted - {1'b0, range_q})
                         : shifted[SAMPLE_BITS-1:0];
  assign quo_next = {quo_q[FRACTION_BITS-2:0], fits};
  assign result   = zero_q ? '0 : (one_q ? NORM_ONE : {1'b0, quo_next});

  // shared divider and result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init) begin
      rem_q   <= s_sel - lo_sel;
      range_q <= hi_sel - lo_sel;
      zero_q  <= !calib_q || (hi_sel <= lo_sel) || (s_sel <= lo_sel);
      one_q   <= (s_sel >= hi_sel);
    end else if (ctrl_i.iterate) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
    end
    if (ctrl_i.finish) begin
      res_q[ctrl_i.ch] <= result;
    end
    if (ctrl_i.publish) begin
      for (int i = 0; i < CHANNELS; i++) norm_q[i] <= res_q[i];
    end
  end

  assign norm_o = norm_q;

endmodule

// ===== design/auto_range_normalizer_unit.sv =====
// Five-channel min/max normalizer with automatic calibration.
// Input channel: in_valid_i / in_stall_o with command_i and value0_i..value4_i.
// Command sample gives one output word norm0_o..norm4_o, each
// (sample-low)/(high-low) clamped to 0..1 in unsigned Q1.16; load-low and
// load-high commands preset the bounds and give no output word.
// Output channel: out_valid_o / out_stall_i; a word stays on the ports until taken.
// A sample runs from acceptance to out_valid_o through one shared restoring
// divider, channel by channel (setup plus 16 quotient bits per channel), and
// then the results move into the output register.
// One sample is in work at a time, so no new sample is taken before the last one
// has moved into the output register; while idle, load commands are taken every cycle.
// The output register decouples the sides: the next word can be accepted while
// the previous result waits; a finished result waits in the block if the
// output register is still stalled, and in_stall_o stays high meanwhile.
// Reset clears the bounds and the calibrated flag and sets auto calibration on.
// APB register at address 0: bit 0 auto_calibrate; write it only while idle.
module auto_range_normalizer_unit import arn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  sample_t            value0_i,
  input  sample_t            value1_i,
  input  sample_t            value2_i,
  input  sample_t            value3_i,
  input  sample_t            value4_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output norm_t              norm0_o,
  output norm_t              norm1_o,
  output norm_t              norm2_o,
  output norm_t              norm3_o,
  output norm_t              norm4_o
);

  logic      auto_q;
  arn_ctrl_t ctrl;
  sample_t   values [CHANNELS];
  norm_t     norms [CHANNELS];

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr == REG_AUTO_CALIBRATE)) begin
      auto_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_AUTO_CALIBRATE) ? {{(PDATA_W-1){1'b0}}, auto_q} : '0;

  assign values[0] = value0_i;
  assign values[1] = value1_i;
  assign values[2] = value2_i;
  assign values[3] = value3_i;
  assign values[4] = value4_i;

  arn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctrl_o      (ctrl)
  );

  arn_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .auto_cal_i (auto_q),
    .command_i  (command_i),
    .values_i   (values),
    .norm_o     (norms)
  );

  assign norm0_o = norms[0];
  assign norm1_o = norms[1];
  assign norm2_o = norms[2];
  assign norm3_o = norms[3];
  assign norm4_o = norms[4];

  // a sample command occupies the block
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && command_i == CMD_SAMPLE) |=> in_stall_o)
    else $error("sample accepted but block still ready");

  // load and reserved commands leave the block ready
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && command_i != CMD_SAMPLE) |=> !in_stall_o)
    else $error("non-sample command made the block busy");

  // publishing raises the output valid
  a_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.publish |=> out_valid_o)
    else $error("publish without output valid");

  // results never exceed one
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (norm0_o <= NORM_ONE && norm1_o <= NORM_ONE && norm2_o <= NORM_ONE
                     && norm3_o <= NORM_ONE && norm4_o <= NORM_ONE))
    else $error("normalized value above one");

endmodule
